// File: hw/rtl/cbim_pkg.sv
package cbim_pkg;

    // Field widths of the two streams, the configuration port and the IRQ counter.
    localparam int ADDR_W    = 4;
    localparam int DATA_W    = 8;
    localparam int SLOT_W    = 3;
    localparam int MIRROR_W  = 2;
    localparam int KIND_W    = 2;
    localparam int CFG_IDX_W = 2;
    localparam int CNT_W     = 16;

    // Stream bus widths (fields packed from the lowest bit, tdata padded to bytes).
    localparam int S_TDATA_W = 16;
    localparam int S_TUSER_W = 1;
    localparam int M_TDATA_W = 16;
    localparam int M_TUSER_W = 2;

    // Widths of the restoring modulo datapath.
    localparam int MOD_W  = 11;
    localparam int DIFF_W = MOD_W + 1;
    localparam int STEP_W = 3;

    // IRQ counter behavior.
    localparam int               COUNT_SHIFT   = 0;
    localparam logic [CNT_W-1:0] STEP_PER_LINE = 16'd114;

    // Item selector carried in tuser.
    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_TICK  = 1'b1;

    // Mapper register addresses above the CHR page registers.
    localparam logic [ADDR_W-1:0] REG_PRG_BANK = 4'h8;
    localparam logic [ADDR_W-1:0] REG_MIRROR   = 4'h9;
    localparam logic [ADDR_W-1:0] REG_IRQ_CTRL = 4'hA;
    localparam logic [ADDR_W-1:0] REG_LATCH_LO = 4'hB;
    localparam logic [ADDR_W-1:0] REG_LATCH_HI = 4'hC;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_CHR_SIZE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PRG_SIZE = 2'd1;

    typedef enum logic [KIND_W-1:0] {
        KIND_NONE   = 2'd0,
        KIND_CHR    = 2'd1,
        KIND_PRG    = 2'd2,
        KIND_MIRROR = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_DIV  = 3'b010,
        ST_OUT  = 3'b100
    } t_state;

endpackage

// File: hw/rtl/cartridge_bank_irq_mapper_top.sv
// Channel     Direction  Handshake                      Payload
// s_axis      in         s_axis_tvalid / s_axis_tready  tuser: func; tdata: reg_addr, write_data
// m_axis      out        m_axis_tvalid / m_axis_tready  tuser: update_kind; tdata: slot..irq
// cfg         in         i_cfg_valid / o_cfg_ready      i_cfg_index, i_cfg_data
//
// A CHR or PRG bank write runs through ST_DIV before its result shows, one pass of the
// shared trial-subtract unit per dividend bit; other items show it the cycle after acceptance.
// Without stalls a bank write passes through ST_IDLE, ST_DIV and ST_OUT from one input
// acceptance to the next, any other item through ST_IDLE and ST_OUT only.
// Reset is synchronous and active low; it clears the IRQ state and sets both ROM sizes to one.
// The input side accepts one item at a time and stays stalled until the result is taken.
module cartridge_bank_irq_mapper_top #(
    parameter int                            COUNT_SHIFT   = cbim_pkg::COUNT_SHIFT,
    parameter logic [cbim_pkg::CNT_W-1:0]    STEP_PER_LINE = cbim_pkg::STEP_PER_LINE
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,

    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [cbim_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [cbim_pkg::DATA_W-1:0]     i_cfg_data,

    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // [3:0] reg_addr, [11:4] write_data, [15:12] zero
    input  logic [cbim_pkg::S_TDATA_W-1:0]  s_axis_tdata,
    // [0] func
    input  logic [cbim_pkg::S_TUSER_W-1:0]  s_axis_tuser,

    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // [2:0] chr_slot, [10:3] bank_page, [12:11] mirror_mode, [13] irq_request, [15:14] zero
    output logic [cbim_pkg::M_TDATA_W-1:0]  m_axis_tdata,
    // [1:0] update_kind
    output logic [cbim_pkg::M_TUSER_W-1:0]  m_axis_tuser
);
    import cbim_pkg::*;

    // Control and mapper state.
    t_state              r_state, n_state;
    logic                r_irq_en, n_irq_en;
    logic [CNT_W-1:0]    r_latch, n_latch;
    logic [CNT_W-1:0]    r_counter, n_counter;
    logic [DATA_W-1:0]   r_chr_size;
    logic [DATA_W-1:0]   r_prg_size;

    // Modulo datapath and result registers.
    logic [DATA_W-1:0]   r_dividend, n_dividend;
    logic [DATA_W-1:0]   r_rem, n_rem;
    logic [MOD_W-1:0]    r_modulus, n_modulus;
    logic [STEP_W-1:0]   r_step, n_step;
    t_kind               r_kind, n_kind;
    logic [SLOT_W-1:0]   r_slot, n_slot;
    logic [DATA_W-1:0]   r_page, n_page;
    logic [MIRROR_W-1:0] r_mirror, n_mirror;
    logic                r_irq, n_irq;

    logic [ADDR_W-1:0]   in_addr;
    logic [DATA_W-1:0]   in_data;
    logic                in_func;
    logic [DATA_W:0]     rem_shift;
    logic [DIFF_W-1:0]   trial_diff;
    logic [DATA_W-1:0]   rem_next;

    assign in_addr = s_axis_tdata[ADDR_W-1:0];
    assign in_data = s_axis_tdata[ADDR_W+DATA_W-1:ADDR_W];
    assign in_func = s_axis_tuser[0];

    // Shared trial-subtract unit: bring down the next dividend bit and subtract
    // the modulus; keep the difference when it does not go negative. The
    // partial remainder never exceeds the dividend prefix, so it fits a byte.
    assign rem_shift  = {r_rem, r_dividend[DATA_W-1]};
    assign trial_diff = {{(DIFF_W-DATA_W-1){1'b0}}, rem_shift} - {1'b0, r_modulus};
    assign rem_next   = trial_diff[DIFF_W-1] ? rem_shift[DATA_W-1:0]
                                             : trial_diff[DATA_W-1:0];

    always_comb begin
        n_state    = r_state;
        n_irq_en   = r_irq_en;
        n_latch    = r_latch;
        n_counter  = r_counter;
        n_dividend = r_dividend;
        n_rem      = r_rem;
        n_modulus  = r_modulus;
        n_step     = r_step;
        n_kind     = r_kind;
        n_slot     = r_slot;
        n_page     = r_page;
        n_mirror   = r_mirror;
        n_irq      = r_irq;

        unique case (r_state)
            ST_IDLE: begin
                if (s_axis_tvalid) begin
                    n_kind   = KIND_NONE;
                    n_slot   = '0;
                    n_page   = '0;
                    n_mirror = '0;
                    n_irq    = 1'b0;
                    n_state  = ST_OUT;
                    if (in_func == FUNC_TICK) begin
                        if (r_irq_en) begin
                            if (r_counter <= STEP_PER_LINE) begin
                                n_irq     = 1'b1;
                                n_counter = '0;
                                n_irq_en  = 1'b0;
                            end else begin
                                n_counter = r_counter - STEP_PER_LINE;
                            end
                        end
                    end else if (!in_addr[ADDR_W-1]) begin
                        // CHR page registers: data modulo eight times the CHR size.
                        n_kind     = KIND_CHR;
                        n_slot     = in_addr[SLOT_W-1:0];
                        n_dividend = in_data;
                        n_modulus  = {r_chr_size, 3'b000};
                        n_rem      = '0;
                        n_step     = '1;
                        n_state    = ST_DIV;
                    end else begin
                        unique case (in_addr)
                            REG_PRG_BANK: begin
                                // Doubled data, truncated, modulo twice the PRG size.
                                n_kind     = KIND_PRG;
                                n_dividend = {in_data[DATA_W-2:0], 1'b0};
                                n_modulus  = {2'b00, r_prg_size, 1'b0};
                                n_rem      = '0;
                                n_step     = '1;
                                n_state    = ST_DIV;
                            end
                            REG_MIRROR: begin
                                n_kind   = KIND_MIRROR;
                                n_mirror = in_data[MIRROR_W-1:0];
                            end
                            REG_IRQ_CTRL: begin
                                n_irq_en  = in_data[0];
                                n_counter = r_latch << COUNT_SHIFT;
                            end
                            REG_LATCH_LO: begin
                                n_latch = {r_latch[CNT_W-1:DATA_W], in_data};
                            end
                            REG_LATCH_HI: begin
                                n_latch = {in_data, r_latch[DATA_W-1:0]};
                            end
                            default: begin
                                // Unused registers leave the mapper state unchanged and report no update.
                                n_kind = KIND_NONE;
                            end
                        endcase
                    end
                end
            end
            ST_DIV: begin
                n_dividend = {r_dividend[DATA_W-2:0], 1'b0};
                n_rem      = rem_next;
                if (r_step == '0) begin
                    n_page  = rem_next;
                    n_state = ST_OUT;
                end else begin
                    n_step = r_step - 1'b1;
                end
            end
            ST_OUT: begin
                if (m_axis_tready) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_irq_en   <= 1'b0;
            r_latch    <= '0;
            r_counter  <= '0;
            r_chr_size <= 8'd1;
            r_prg_size <= 8'd1;
        end else begin
            r_state   <= n_state;
            r_irq_en  <= n_irq_en;
            r_latch   <= n_latch;
            r_counter <= n_counter;
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == CFG_CHR_SIZE) begin
                    r_chr_size <= i_cfg_data;
                end else if (i_cfg_index == CFG_PRG_SIZE) begin
                    r_prg_size <= i_cfg_data;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_dividend <= n_dividend;
        r_rem      <= n_rem;
        r_modulus  <= n_modulus;
        r_step     <= n_step;
        r_kind     <= n_kind;
        r_slot     <= n_slot;
        r_page     <= n_page;
        r_mirror   <= n_mirror;
        r_irq      <= n_irq;
    end

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = (r_state == ST_OUT);
    assign m_axis_tuser  = r_kind;
    assign m_axis_tdata  = {2'b00, r_irq, r_mirror, r_page, r_slot};

endmodule

// File: bench/tb_cartridge_bank_irq_mapper_top.sv
// Self-checking bench for the cartridge bank and scanline IRQ mapper.
// A scoreboard object keeps its own copy of the mapper state and ROM sizes.
// For every item the block accepts, it works out the update that must come back.
// Results are checked in order against the queued updates, field by field.
module tb_cartridge_bank_irq_mapper_top;
    import cbim_pkg::*;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 12;
    localparam int MAX_GAP       = 12;
    localparam int RESET_CYCLES  = 11;
    localparam int RANDOM_ITEMS  = 600;
    localparam int PHASES        = 6;

    // Bit positions of the result fields inside m_axis_tdata.
    localparam int PAGE_LSB   = SLOT_W;
    localparam int MIRROR_LSB = PAGE_LSB + DATA_W;
    localparam int IRQ_BIT    = MIRROR_LSB + MIRROR_W;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [DATA_W-1:0]     i_cfg_data;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [S_TDATA_W-1:0]  s_axis_tdata;
    logic [S_TUSER_W-1:0]  s_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [M_TDATA_W-1:0]  m_axis_tdata;
    logic [M_TUSER_W-1:0]  m_axis_tuser;

    // One bank or IRQ update as the block reports it.
    typedef struct packed {
        t_kind               kind;
        logic [SLOT_W-1:0]   slot;
        logic [DATA_W-1:0]   page;
        logic [MIRROR_W-1:0] mirror;
        logic                irq;
    } t_map_update;

    class t_map_scoreboard;
        logic [DATA_W-1:0] chr_size;
        logic [DATA_W-1:0] prg_size;
        logic              irq_on;
        logic [CNT_W-1:0]  irq_latch;
        logic [CNT_W-1:0]  irq_count;
        t_map_update       expected_updates[$];
        int                fail_count;

        function new();
            chr_size   = 8'd1;
            prg_size   = 8'd1;
            irq_on     = 1'b0;
            irq_latch  = '0;
            irq_count  = '0;
            fail_count = 0;
        endfunction

        function void set_size(logic [CFG_IDX_W-1:0] idx, logic [DATA_W-1:0] value);
            if (idx == CFG_CHR_SIZE) begin
                chr_size = value;
            end else if (idx == CFG_PRG_SIZE) begin
                prg_size = value;
            end
        endfunction

        function int pending();
            return expected_updates.size();
        endfunction

        // Works out the update for one accepted item and advances the IRQ state.
        function void note_input(logic func, logic [ADDR_W-1:0] addr, logic [DATA_W-1:0] data);
            t_map_update upd;
            int          modulus;
            upd        = '0;
            upd.kind   = KIND_NONE;
            if (func == FUNC_TICK) begin
                // Address and data of a tick are don't-care.
                if (!irq_on) begin
                    upd.irq = 1'b0;
                end else if (irq_count <= STEP_PER_LINE) begin
                    upd.irq   = 1'b1;
                    irq_count = '0;
                    irq_on    = 1'b0;
                end else begin
                    irq_count = irq_count - STEP_PER_LINE;
                end
            end else if (addr < REG_PRG_BANK) begin
                upd.kind = KIND_CHR;
                upd.slot = addr[SLOT_W-1:0];
                modulus  = int'(chr_size) << 3;
                upd.page = (modulus == 0) ? data : DATA_W'(int'(data) % modulus);
            end else if (addr == REG_PRG_BANK) begin
                upd.kind = KIND_PRG;
                modulus  = int'(prg_size) << 1;
                upd.page = (modulus == 0) ? {data[DATA_W-2:0], 1'b0}
                                          : DATA_W'(int'({data[DATA_W-2:0], 1'b0}) % modulus);
            end else if (addr == REG_MIRROR) begin
                upd.kind   = KIND_MIRROR;
                upd.mirror = data[MIRROR_W-1:0];
            end else if (addr == REG_IRQ_CTRL) begin
                irq_on    = data[0];
                irq_count = CNT_W'(32'(irq_latch) << COUNT_SHIFT);
            end else if (addr == REG_LATCH_LO) begin
                irq_latch[DATA_W-1:0] = data;
            end else if (addr == REG_LATCH_HI) begin
                irq_latch[CNT_W-1:DATA_W] = data;
            end
            expected_updates.push_back(upd);
        endfunction

        function void report_mismatch(string what, int got, int want);
            $display("mismatch: %s got %0d expected %0d", what, got, want);
            fail_count++;
        endfunction

        function void check_result(logic [M_TDATA_W-1:0] tdata, logic [M_TUSER_W-1:0] tuser);
            t_map_update want;
            if (expected_updates.size() == 0) begin
                report_mismatch("result with nothing outstanding, kind", int'(tuser), -1);
                return;
            end
            want = expected_updates.pop_front();
            if (tuser != want.kind)
                report_mismatch("update_kind", int'(tuser), int'(want.kind));
            if (tdata[SLOT_W-1:0] != want.slot)
                report_mismatch("chr_slot", int'(tdata[SLOT_W-1:0]), int'(want.slot));
            if (tdata[PAGE_LSB +: DATA_W] != want.page)
                report_mismatch("bank_page", int'(tdata[PAGE_LSB +: DATA_W]), int'(want.page));
            if (tdata[MIRROR_LSB +: MIRROR_W] != want.mirror)
                report_mismatch("mirror_mode", int'(tdata[MIRROR_LSB +: MIRROR_W]),
                                int'(want.mirror));
            if (tdata[IRQ_BIT] != want.irq)
                report_mismatch("irq_request", int'(tdata[IRQ_BIT]), int'(want.irq));
            if (tdata[M_TDATA_W-1:IRQ_BIT+1] != '0)
                report_mismatch("tdata padding", int'(tdata[M_TDATA_W-1:IRQ_BIT+1]), 0);
        endfunction
    endclass

    t_map_scoreboard sb;
    int              cycle_count;
    bit              tx_idle_on;
    bit              rx_idle_on;
    int              sent_items;

    cartridge_bank_irq_mapper_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Watchdog: a hung handshake or a lost result ends the run here.
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("CHECK FAILED");
        $finish;
    end

    // Result side. Before each item, while rx_idle_on is set, it holds tready low for a
    // random gap, then takes the item and hands it to the scoreboard. Inputs change on
    // the falling edge only, so the rising edge sees settled values.
    initial begin
        int gap;
        m_axis_tready = 1'b0;
        @(posedge i_rst_n);
        @(negedge i_clk);
        forever begin
            gap = rx_idle_on ? $urandom_range(0, MAX_GAP) : 0;
            if (gap > 0) begin
                m_axis_tready = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            m_axis_tready = 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
            sb.check_result(m_axis_tdata, m_axis_tuser);
            @(negedge i_clk);
        end
    end

    // Sends one item, after a random gap when tx_idle_on is set. It is called and returns at a
    // falling edge, and tvalid stays high across back-to-back items.
    task automatic push_item(input logic func, input logic [ADDR_W-1:0] addr,
                             input logic [DATA_W-1:0] data);
        int gap;
        gap = tx_idle_on ? $urandom_range(0, MAX_GAP) : 0;
        if (gap > 0) begin
            s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tuser  = func;
        s_axis_tdata  = {{(S_TDATA_W-ADDR_W-DATA_W){1'b0}}, data, addr};
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_input(func, addr, data);
        sent_items++;
        @(negedge i_clk);
    endtask

    // Holds the sender off until every outstanding result has come back. A settling
    // wait then lets the block come to rest before its registers are touched.
    task automatic drain_results();
        s_axis_tvalid = 1'b0;
        while (sb.pending() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_config(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] value);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = value;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.set_size(idx, value);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // An IRQ program: load the latch, write the control register (enable set most
    // of the time), then send ticks up to about where the count fires. Bank and
    // mirror writes are mixed in, since they must not disturb the count.
    task automatic run_irq_sequence();
        logic [DATA_W-1:0] lo;
        logic [DATA_W-1:0] hi;
        logic [DATA_W-1:0] ctrl;
        int                ticks;
        lo = DATA_W'($urandom);
        hi = ($urandom_range(0, 9) == 0) ? DATA_W'($urandom) : DATA_W'($urandom_range(0, 3));
        ctrl = DATA_W'($urandom);
        ctrl[0] = ($urandom_range(0, 6) != 0);
        push_item(FUNC_WRITE, REG_LATCH_LO, lo);
        push_item(FUNC_WRITE, REG_LATCH_HI, hi);
        push_item(FUNC_WRITE, REG_IRQ_CTRL, ctrl);
        // With the high latch byte above three the count would need more ticks, so only one to four are sent.
        if (hi > 3)
            ticks = $urandom_range(1, 4);
        else
            ticks = int'({hi, lo}) / int'(STEP_PER_LINE) + $urandom_range(0, 2);
        while (ticks > 0) begin
            if ($urandom_range(0, 6) == 0) begin
                push_item(FUNC_WRITE, ADDR_W'($urandom_range(0, int'(REG_MIRROR))),
                          DATA_W'($urandom));
            end else begin
                push_item(FUNC_TICK, ADDR_W'($urandom), DATA_W'($urandom));
                ticks--;
            end
        end
    endtask

    initial begin
        int phase_goal;
        int pick;
        logic [DATA_W-1:0] chr_cfg;
        logic [DATA_W-1:0] prg_cfg;

        sb            = new();
        i_rst_n       = 1'b0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = '0;
        i_cfg_data    = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        tx_idle_on    = 1'b1;
        rx_idle_on    = 1'b1;
        sent_items    = 0;
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed part, run with the reset sizes of one 8K CHR and one 16K PRG unit.
        push_item(FUNC_WRITE, 4'd0, 8'hFF);
        push_item(FUNC_WRITE, 4'd7, 8'h00);
        push_item(FUNC_WRITE, 4'd3, 8'h80);
        push_item(FUNC_WRITE, REG_PRG_BANK, 8'hFF);
        // Doubling 0x80 wraps the PRG page to zero.
        push_item(FUNC_WRITE, REG_PRG_BANK, 8'h80);
        push_item(FUNC_WRITE, REG_MIRROR, 8'hFC);
        push_item(FUNC_WRITE, REG_MIRROR, 8'h01);
        push_item(FUNC_WRITE, REG_MIRROR, 8'h02);
        push_item(FUNC_WRITE, REG_MIRROR, 8'hFF);
        // Unused registers report no update.
        push_item(FUNC_WRITE, 4'hD, 8'hFF);
        push_item(FUNC_WRITE, 4'hF, 8'h5A);
        // A tick with the IRQ off changes nothing, whatever its address and data.
        push_item(FUNC_TICK, 4'hF, 8'hFF);
        // Counter exactly at the step fires on the first tick.
        push_item(FUNC_WRITE, REG_LATCH_LO, 8'h72);
        push_item(FUNC_WRITE, REG_LATCH_HI, 8'h00);
        push_item(FUNC_WRITE, REG_IRQ_CTRL, 8'h01);
        push_item(FUNC_TICK, 4'h0, 8'h00);
        push_item(FUNC_TICK, 4'h0, 8'h00);
        // One above the step needs a second tick.
        push_item(FUNC_WRITE, REG_LATCH_LO, 8'h73);
        push_item(FUNC_WRITE, REG_IRQ_CTRL, 8'hFF);
        push_item(FUNC_TICK, 4'hA, 8'h01);
        push_item(FUNC_TICK, 4'h5, 8'hFE);
        // Full latch loaded with the IRQ left disabled.
        push_item(FUNC_WRITE, REG_LATCH_HI, 8'hFF);
        push_item(FUNC_WRITE, REG_LATCH_LO, 8'hFF);
        push_item(FUNC_WRITE, REG_IRQ_CTRL, 8'h00);
        push_item(FUNC_TICK, 4'h0, 8'h00);

        // Wait for everything to come back before the random phases.
        drain_results();

        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0: begin
                    chr_cfg = 8'd255;
                    prg_cfg = 8'd255;
                end
                1: begin
                    chr_cfg = 8'd1;
                    prg_cfg = 8'd255;
                end
                2: begin
                    chr_cfg = 8'd255;
                    prg_cfg = 8'd1;
                end
                4: begin
                    chr_cfg = 8'd1;
                    prg_cfg = 8'd1;
                end
                default: begin
                    chr_cfg = DATA_W'($urandom_range(1, 255));
                    prg_cfg = DATA_W'($urandom_range(1, 255));
                end
            endcase
            write_config(CFG_CHR_SIZE, chr_cfg);
            write_config(CFG_PRG_SIZE, prg_cfg);

            // One phase runs flat out on both sides, two others on one side only.
            tx_idle_on = (p != 2) && (p != 4);
            rx_idle_on = (p != 2) && (p != 5);

            phase_goal = sent_items + RANDOM_ITEMS / PHASES;
            while (sent_items < phase_goal) begin
                pick = $urandom_range(0, 99);
                if (pick < 40) begin
                    run_irq_sequence();
                end else if (pick < 75) begin
                    push_item(FUNC_WRITE, ADDR_W'($urandom_range(0, int'(REG_MIRROR))),
                              DATA_W'($urandom));
                end else if (pick < 98) begin
                    // Noise: any item at all, including stray IRQ writes.
                    push_item(logic'($urandom), ADDR_W'($urandom), DATA_W'($urandom));
                end else begin
                    drain_results();
                end
            end
            drain_results();
        end

        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (sb.fail_count == 0 && sb.pending() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
